// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define TBDH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tbdh assertion failed");

// Clocked assertion that also holds during reset
`define TBDH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tbdh assertion failed");

`endif

// ===== rtl/tbdh_pkg.sv =====
// Shared types, constants and codes of the two-button debounce block
`timescale 1ns / 1ps

package tbdh_pkg;

    // Time and register widths
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int NOW_WIDTH       = 32;
    localparam int CFG_WIDTH       = 16;
    localparam int IN_TDATA_WIDTH  = 40;
    localparam int OUT_TDATA_WIDTH = 8;
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;

    // Register reset values in milliseconds
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd2000;

    // Register select, taken from address bit 2
    localparam logic REG_SEL_DEBOUNCE = 1'b0;
    localparam logic REG_SEL_HOLD     = 1'b1;

    // First button event codes
    typedef logic [1:0] talk_event_t;
    localparam talk_event_t EVT_NONE = 2'd0;
    localparam talk_event_t EVT_DOWN = 2'd1;
    localparam talk_event_t EVT_UP   = 2'd2;

    // Configuration register contents
    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_time;
        logic [CFG_WIDTH-1:0] hold_time;
    } tbdh_cfg_t;

    // Debounced button status for the current poll
    typedef struct packed {
        logic changed;
        logic level;
    } tbdh_btn_t;

    // Second button press events
    typedef struct packed {
        logic aux_short;
        logic aux_hold;
    } tbdh_aux_evt_t;

endpackage

// ===== rtl/two_button_debounce_hold.sv =====
// Two-button debounce with press events and long-press hold detection
//
// Usage: each slave-side stream transaction is one poll carrying the current
// millisecond time and the raw levels of two buttons. Every poll yields
// exactly one master-side transaction with the first button's down/up event,
// the second button's short-press and hold flags, and both debounced levels.
// A poll goes through the input register and then the result register,
// which drives m_tdata; one poll is taken per cycle unless m_tready stalls.
// The rate is set by the state update between the input register and the
// result register, so each poll sees the state left by the one before it.
// When m_tready is low the result register holds its transaction and the
// input register still takes one more poll; s_tready then falls until the
// result is taken. Reset clears all button state and both valid flags, and
// loads debounce_time = 50 ms and hold_time = 2000 ms; no clearing pass. The APB port
// writes the two times (byte address 0 and 4); the user must do so only while idle, as the block does not check it.
`timescale 1ns / 1ps

module two_button_debounce_hold
    import tbdh_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // s_tdata: now_ms[31:0], talk_raw[32], aux_raw[33], zero [39:34]
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
    // m_tdata: talk_event[1:0], aux_short[2], aux_hold[3], talk_level[4],
    //          aux_level[5], zero [7:6]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [APB_DATA_WIDTH-1:0]  pwdata,
    output logic [APB_DATA_WIDTH-1:0]  prdata,
    output logic                       pready
);

    tbdh_cfg_t             cfg;
    tbdh_btn_t             talk_st;
    tbdh_btn_t             aux_st;
    tbdh_aux_evt_t         aux_evt;
    talk_event_t           talk_event;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [TIME_WIDTH-1:0] in_now_reg;
    logic                  in_talk_reg;
    logic                  in_aux_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [5:0]            out_data_reg;
    logic [5:0]            result;
    logic                  s_take;
    logic                  advance;
    logic                  fire;

    // Handshake: move on when the result register is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the poll; time is cut or zero-extended to the internal width
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_now_reg  <= TIME_WIDTH'({{NOW_WIDTH{1'b0}}, s_tdata[NOW_WIDTH-1:0]});
            in_talk_reg <= s_tdata[NOW_WIDTH];
            in_aux_reg  <= s_tdata[NOW_WIDTH+1];
        end
    end

    tbdh_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbdh_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_talk (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .raw           (in_talk_reg),
        .now           (in_now_reg),
        .debounce_time (cfg.debounce_time),
        .status        (talk_st)
    );

    tbdh_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_aux (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .raw           (in_aux_reg),
        .now           (in_now_reg),
        .debounce_time (cfg.debounce_time),
        .status        (aux_st)
    );

    tbdh_hold #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .now       (in_now_reg),
        .aux       (aux_st),
        .hold_time (cfg.hold_time),
        .evt       (aux_evt)
    );

    // Build the result transaction
    always_comb
    begin
        if (!talk_st.changed)
            talk_event = EVT_NONE;
        else if (talk_st.level)
            talk_event = EVT_DOWN;
        else
            talk_event = EVT_UP;
    end

    assign result = {aux_st.level, talk_st.level, aux_evt.aux_hold,
                     aux_evt.aux_short, talk_event};

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_WIDTH - 6){1'b0}}, out_data_reg};

endmodule

// ===== rtl/tbdh_cfg.sv =====
// APB register file holding the debounce and hold times
`timescale 1ns / 1ps

module tbdh_cfg
    import tbdh_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output tbdh_cfg_t                 cfg
);

    logic                 wr_en;
    logic [CFG_WIDTH-1:0] debounce_reg;
    logic [CFG_WIDTH-1:0] debounce_next;
    logic [CFG_WIDTH-1:0] hold_reg;
    logic [CFG_WIDTH-1:0] hold_next;
    logic [CFG_WIDTH-1:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Decode the write transaction
    always_comb
    begin
        debounce_next = debounce_reg;
        hold_next     = hold_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_SEL_DEBOUNCE: debounce_next = pwdata[CFG_WIDTH-1:0];
                REG_SEL_HOLD:     hold_next     = pwdata[CFG_WIDTH-1:0];
                default:          debounce_next = debounce_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            hold_reg     <= HOLD_RESET;
        end
        else
        begin
            debounce_reg <= debounce_next;
            hold_reg     <= hold_next;
        end
    end

    // Return the selected register
    always_comb
    begin
        unique case (paddr[2])
            REG_SEL_DEBOUNCE: rd_val = debounce_reg;
            REG_SEL_HOLD:     rd_val = hold_reg;
            default:          rd_val = debounce_reg;
        endcase
    end

    assign prdata = {{(APB_DATA_WIDTH - CFG_WIDTH){1'b0}}, rd_val};

    assign cfg.debounce_time = debounce_reg;
    assign cfg.hold_time     = hold_reg;

endmodule

// ===== rtl/tbdh_debounce.sv =====
// Debounce state and level decision for one button
`timescale 1ns / 1ps

module tbdh_debounce
    import tbdh_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  raw,
    input  logic [TIME_WIDTH-1:0] now,
    input  logic [CFG_WIDTH-1:0]  debounce_time,
    output tbdh_btn_t             status
);

    logic                  prev_raw_reg;
    logic                  prev_raw_next;
    logic                  stable_reg;
    logic                  stable_next;
    logic [TIME_WIDTH-1:0] change_at_reg;
    logic [TIME_WIDTH-1:0] change_at_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  raw_moved;
    logic                  accept;

    // Elapsed time since the last raw change, wrapping
    assign elapsed   = now - change_at_reg;
    assign raw_moved = (raw != prev_raw_reg);
    assign accept    = !raw_moved && (raw != stable_reg) &&
                       (elapsed >= TIME_WIDTH'(debounce_time));

    // A raw change only records itself; a steady level may be accepted
    always_comb
    begin
        prev_raw_next  = prev_raw_reg;
        change_at_next = change_at_reg;
        stable_next    = stable_reg;
        if (fire)
        begin
            if (raw_moved)
            begin
                prev_raw_next  = raw;
                change_at_next = now;
            end
            else if (accept)
            begin
                stable_next = raw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg  <= 1'b0;
            stable_reg    <= 1'b0;
            change_at_reg <= '0;
        end
        else
        begin
            prev_raw_reg  <= prev_raw_next;
            stable_reg    <= stable_next;
            change_at_reg <= change_at_next;
        end
    end

    assign status.changed = accept;
    assign status.level   = accept ? raw : stable_reg;

endmodule

// ===== rtl/tbdh_hold.sv =====
// Short press and long hold detection for the second button
`timescale 1ns / 1ps

module tbdh_hold
    import tbdh_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [TIME_WIDTH-1:0] now,
    input  tbdh_btn_t             aux,
    input  logic [CFG_WIDTH-1:0]  hold_time,
    output tbdh_aux_evt_t         evt
);

    logic [TIME_WIDTH-1:0] press_at_reg;
    logic [TIME_WIDTH-1:0] press_at_next;
    logic                  hold_done_reg;
    logic                  hold_done_next;
    logic                  pressed;
    logic [TIME_WIDTH-1:0] press_at_eff;
    logic                  hold_done_eff;
    logic [TIME_WIDTH-1:0] held_for;
    logic                  hold_fire;

    // A fresh debounced press restarts the hold timer
    assign pressed       = aux.changed && aux.level;
    assign press_at_eff  = pressed ? now : press_at_reg;
    assign hold_done_eff = pressed ? 1'b0 : hold_done_reg;
    assign held_for      = now - press_at_eff;
    assign hold_fire     = aux.level && !hold_done_eff &&
                           (held_for >= TIME_WIDTH'(hold_time));

    assign evt.aux_short = aux.changed && !aux.level && !hold_done_reg;
    assign evt.aux_hold  = hold_fire;

    always_comb
    begin
        press_at_next  = press_at_reg;
        hold_done_next = hold_done_reg;
        if (fire)
        begin
            press_at_next  = press_at_eff;
            hold_done_next = hold_done_eff || hold_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_at_reg  <= '0;
            hold_done_reg <= 1'b0;
        end
        else
        begin
            press_at_reg  <= press_at_next;
            hold_done_reg <= hold_done_next;
        end
    end

endmodule

// ===== rtl/tbdh_checker.sv =====
// Port-level checker for the two-button debounce block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbdh_checker
    import tbdh_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

    // A down event leaves the level pressed, an up event released
    `TBDH_ASSERT(a_talk_evt_level, clk, rst_n, (m_tvalid && (m_tdata[1:0] == EVT_DOWN)) |-> m_tdata[4])
    `TBDH_ASSERT(a_talk_up_level, clk, rst_n, (m_tvalid && (m_tdata[1:0] == EVT_UP)) |-> !m_tdata[4])

    // A short press comes with release, a hold with the button down, never both
    `TBDH_ASSERT(a_aux_evt_level, clk, rst_n, m_tvalid |-> (!m_tdata[2] || (!m_tdata[5] && !m_tdata[3])) && (!m_tdata[3] || m_tdata[5]))

    // Hold a stalled result
    `TBDH_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // No result while reset is applied
    `TBDH_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !m_tvalid)

endmodule

bind two_button_debounce_hold tbdh_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the two-button debounce and hold block
`timescale 1ns / 1ps

module tb;
    import tbdh_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL     = 80;
    localparam int DRAIN_CYCLES   = 4;

    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_DEBOUNCE = 3'd0;
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_HOLD     = 3'd4;

    // One poll result, field by field
    typedef struct packed {
        talk_event_t talk_event;
        logic        aux_short;
        logic        aux_hold;
        logic        talk_level;
        logic        aux_level;
    } poll_result_t;

    // Button state tracker and store of the results still owed by the block
    class poll_scoreboard;
        logic [CFG_WIDTH-1:0] deb_limit;
        logic [CFG_WIDTH-1:0] hold_ms;
        bit                   talk_raw_q;
        bit                   talk_level_q;
        logic [31:0]          talk_mark;
        bit                   aux_raw_q;
        bit                   aux_level_q;
        logic [31:0]          aux_mark;
        logic [31:0]          aux_press_mark;
        bit                   aux_hold_seen;
        poll_result_t         pending_results[$];
        int                   mismatches;

        function new();
            deb_limit      = DEBOUNCE_RESET;
            hold_ms        = HOLD_RESET;
            talk_raw_q     = 1'b0;
            talk_level_q   = 1'b0;
            talk_mark      = '0;
            aux_raw_q      = 1'b0;
            aux_level_q    = 1'b0;
            aux_mark       = '0;
            aux_press_mark = '0;
            aux_hold_seen  = 1'b0;
            mismatches     = 0;
        endfunction

        function void set_config(logic [CFG_WIDTH-1:0] deb, logic [CFG_WIDTH-1:0] hold);
            deb_limit = deb;
            hold_ms   = hold;
        endfunction

        // Record a raw change, or accept a steady raw level once debounced
        function bit settle(input bit raw, input logic [31:0] now_v, inout bit seen_raw,
                            inout bit level, inout logic [31:0] mark);
            logic [31:0] gap;
            settle = 1'b0;
            if (raw != seen_raw) begin
                seen_raw = raw;
                mark     = now_v;
            end
            else if (raw != level) begin
                gap = now_v - mark;
                if (gap >= {16'd0, deb_limit}) begin
                    level  = raw;
                    settle = 1'b1;
                end
            end
        endfunction

        function void note_poll(logic [31:0] now_v, bit talk, bit aux);
            poll_result_t r;
            logic [31:0]  gap;
            r = '0;
            r.talk_event = EVT_NONE;
            if (settle(talk, now_v, talk_raw_q, talk_level_q, talk_mark))
                r.talk_event = talk_level_q ? EVT_DOWN : EVT_UP;
            if (settle(aux, now_v, aux_raw_q, aux_level_q, aux_mark)) begin
                if (aux_level_q) begin
                    aux_press_mark = now_v;
                    aux_hold_seen  = 1'b0;
                end
                else if (!aux_hold_seen) begin
                    r.aux_short = 1'b1;
                end
            end
            // Hold test comes last, so a zero hold time fires on the press itself
            gap = now_v - aux_press_mark;
            if (aux_level_q && !aux_hold_seen && gap >= {16'd0, hold_ms}) begin
                aux_hold_seen = 1'b1;
                r.aux_hold    = 1'b1;
            end
            r.talk_level = talk_level_q;
            r.aux_level  = aux_level_q;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_WIDTH-1:0] word);
            poll_result_t want;
            poll_result_t got;
            got.talk_event = word[1:0];
            got.aux_short  = word[2];
            got.aux_hold   = word[3];
            got.talk_level = word[4];
            got.aux_level  = word[5];
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected poll result %h at %0t", word, $realtime);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.talk_event !== want.talk_event || got.aux_short !== want.aux_short ||
                got.aux_hold !== want.aux_hold || got.talk_level !== want.talk_level ||
                got.aux_level !== want.aux_level || word[7:6] !== 2'b00) begin
                if (mismatches < 10)
                    $display({"poll result mismatch at %0t: expected ev=%0d short=%0b ",
                              "hold=%0b tl=%0b al=%0b, got ev=%0d short=%0b hold=%0b ",
                              "tl=%0b al=%0b pad=%b"}, $realtime,
                             want.talk_event, want.aux_short, want.aux_hold,
                             want.talk_level, want.aux_level, got.talk_event,
                             got.aux_short, got.aux_hold, got.talk_level, got.aux_level,
                             word[7:6]);
                mismatches++;
            end
        endfunction
    endclass

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b1;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [APB_ADDR_WIDTH-1:0]  paddr    = '0;
    logic [APB_DATA_WIDTH-1:0]  pwdata   = '0;
    logic [APB_DATA_WIDTH-1:0]  prdata;
    logic                       pready;

    poll_scoreboard sb;
    bit             tx_idle_en     = 1'b1;
    bit             rx_idle_en     = 1'b1;
    bit             long_stall_req = 1'b0;
    logic [31:0]    clock_ms       = '0;
    bit             cur_talk       = 1'b0;
    bit             cur_aux        = 1'b0;
    int             quiet_cycles   = 0;

    two_button_debounce_hold dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // now_ms[31:0], talk_raw[32], aux_raw[33], zero [39:34]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // talk_event[1:0], aux_short[2], aux_hold[3],
                               // talk_level[4], aux_level[5], zero [7:6]
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Note accepted polls, check accepted results, and watch for a hang
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_poll(s_tdata[31:0], s_tdata[32], s_tdata[33]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge clk);
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one poll and hold it until the block takes it
    task automatic send_poll(input logic [31:0] t, input bit talk, input bit aux);
        int gap_len;
        if (tx_idle_en && $urandom_range(0, 9) == 0) begin
            gap_len = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, aux, talk, t};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_WIDTH-1:0] addr,
                             input logic [CFG_WIDTH-1:0] value);
        logic [15:0] junk;
        junk = 16'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_WIDTH-1:0] addr,
                            input logic [CFG_WIDTH-1:0] want);
        logic [APB_DATA_WIDTH-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== {16'd0, want}) begin
            if (sb.mismatches < 10)
                $display("register readback mismatch at address %0d: expected %h, got %h",
                         addr, {16'd0, want}, got);
            sb.mismatches++;
        end
    endtask

    // Change both times while the block is idle, then read them back
    task automatic configure(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] hold);
        wait_drained();
        apb_write(ADDR_DEBOUNCE, deb);
        apb_write(ADDR_HOLD, hold);
        sb.set_config(deb, hold);
        apb_read(ADDR_DEBOUNCE, deb);
        apb_read(ADDR_HOLD, hold);
    endtask

    // Time step scaled to the current debounce and hold times
    function automatic logic [31:0] pick_step(int kind);
        int deb;
        int hold;
        deb  = sb.deb_limit;
        hold = sb.hold_ms;
        case (kind)
            0:       pick_step = $urandom_range(0, deb / 2);
            1:       pick_step = deb + $urandom_range(0, deb / 2 + 1);
            2:       pick_step = $urandom_range(0, hold / 3 + 1);
            default: pick_step = $urandom_range(hold / 2, hold + 10);
        endcase
    endfunction

    // Mostly steady press and release runs, with bounces and noise mixed in
    task automatic random_polls(input int count);
        int done;
        int kind;
        int runs;
        int step_kind;
        done = 0;
        while (done < count) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise: arbitrary jumps of time and raw levels
                runs = $urandom_range(1, 3);
                repeat (runs) begin
                    if ($urandom_range(0, 3) == 0)
                        clock_ms = $urandom;
                    else
                        clock_ms = clock_ms + $urandom_range(0, 3);
                    cur_talk = 1'($urandom_range(0, 1));
                    cur_aux  = 1'($urandom_range(0, 1));
                    send_poll(clock_ms, cur_talk, cur_aux);
                    done++;
                end
            end
            else if (kind == 1) begin
                // bounce: flip a raw level for one poll, then back
                clock_ms = clock_ms + $urandom_range(0, 5);
                send_poll(clock_ms, cur_talk ^ 1'($urandom_range(0, 1)), cur_aux ^ 1'b1);
                clock_ms = clock_ms + $urandom_range(0, 5);
                send_poll(clock_ms, cur_talk, cur_aux);
                done += 2;
            end
            else begin
                // steady run at new levels
                if ($urandom_range(0, 1)) cur_talk = ~cur_talk;
                if ($urandom_range(0, 2) != 0) cur_aux = ~cur_aux;
                runs      = $urandom_range(2, 8);
                step_kind = $urandom_range(0, 3);
                repeat (runs) begin
                    clock_ms = clock_ms + pick_step(step_kind);
                    send_poll(clock_ms, cur_talk, cur_aux);
                    done++;
                end
            end
        end
    endtask

    initial begin
        // Assert reset before the first clock edge
        rst_n <= 1'b0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: debounce edges, short press, hold, wrap and backwards time
        send_poll(32'd0, 1'b0, 1'b0);
        send_poll(32'd10, 1'b1, 1'b0);
        send_poll(32'd30, 1'b1, 1'b0);
        send_poll(32'd60, 1'b1, 1'b0);
        send_poll(32'd70, 1'b1, 1'b1);
        send_poll(32'd120, 1'b1, 1'b1);
        send_poll(32'd200, 1'b1, 1'b0);
        send_poll(32'd260, 1'b1, 1'b0);
        send_poll(32'd300, 1'b0, 1'b0);
        send_poll(32'd349, 1'b0, 1'b0);
        send_poll(32'd350, 1'b0, 1'b0);
        send_poll(32'd400, 1'b0, 1'b1);
        send_poll(32'd450, 1'b0, 1'b1);
        send_poll(32'd2449, 1'b0, 1'b1);
        send_poll(32'd2450, 1'b0, 1'b1);
        send_poll(32'd2500, 1'b0, 1'b0);
        send_poll(32'd2600, 1'b0, 1'b0);
        send_poll(32'hFFFF_FFF0, 1'b1, 1'b0);
        send_poll(32'h0000_0020, 1'b1, 1'b0);
        send_poll(32'h0000_0022, 1'b1, 1'b0);
        send_poll(32'h0000_0010, 1'b0, 1'b0);
        send_poll(32'h0000_0005, 1'b0, 1'b0);
        clock_ms = 32'h0000_0005;
        cur_talk = 1'b0;
        cur_aux  = 1'b0;
        random_polls(100);

        // Zero times: press accepted and held on one poll, release gives no short
        configure(16'd0, 16'd0);
        send_poll(clock_ms, 1'b1, 1'b1);
        send_poll(clock_ms, 1'b1, 1'b1);
        send_poll(clock_ms + 1, 1'b0, 1'b0);
        send_poll(clock_ms + 1, 1'b0, 1'b0);
        clock_ms = clock_ms + 1;
        cur_talk = 1'b0;
        cur_aux  = 1'b0;
        // long receiver hold-off while polls keep coming
        tx_idle_en     = 1'b0;
        long_stall_req = 1'b1;
        random_polls(40);
        tx_idle_en = 1'b1;
        random_polls(60);

        // Largest times
        configure(16'hFFFF, 16'hFFFF);
        random_polls(100);

        // Random times, with a full drain in the middle
        configure(16'($urandom_range(1, 200)), 16'($urandom_range(0, 3000)));
        random_polls(50);
        wait_drained();
        random_polls(50);

        // Short times and no idling on either side
        configure(16'd5, 16'd100);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_polls(80);

        wait_drained();
        sb.mismatches += sb.pending_results.size();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
